// ===== hw/rtl/moc_pkg.sv =====
// Package for the opcode classifier: group and pattern table functions.
// No dependencies.
package moc_pkg;

    localparam int NumPatterns = 170;
    localparam int NumGroups   = 18;

    typedef logic [31:0] word_t;
    typedef logic [7:0]  id_t;

    typedef struct packed {
        logic known;
        id_t  id;
    } class_t;

    typedef struct packed {
        word_t addr;
        word_t word;
    } item_t;

    function automatic word_t pattern_at(input int i);
        word_t p;
        unique case (i)
            0: p = 32'h00000000;
            1: p = 32'h00000002; 2: p = 32'h00200002;
            3: p = 32'h00000006; 4: p = 32'h00000046;
            5: p = 32'h00000000; 6: p = 32'h00000003; 7: p = 32'h00000004;
            8: p = 32'h00000007; 9: p = 32'h00000008; 10: p = 32'h00000009;
            11: p = 32'h0000000a; 12: p = 32'h0000000b; 13: p = 32'h0000000c;
            14: p = 32'h0000000d; 15: p = 32'h0000000f; 16: p = 32'h00000010;
            17: p = 32'h00000011; 18: p = 32'h00000012; 19: p = 32'h00000013;
            20: p = 32'h00000016; 21: p = 32'h00000017; 22: p = 32'h00000018;
            23: p = 32'h00000019; 24: p = 32'h0000001a; 25: p = 32'h0000001b;
            26: p = 32'h0000001c; 27: p = 32'h0000001d; 28: p = 32'h00000020;
            29: p = 32'h00000021; 30: p = 32'h00000022; 31: p = 32'h00000023;
            32: p = 32'h00000024; 33: p = 32'h00000025; 34: p = 32'h00000026;
            35: p = 32'h00000027; 36: p = 32'h0000002a; 37: p = 32'h0000002b;
            38: p = 32'h0000002c; 39: p = 32'h0000002d; 40: p = 32'h0000002e;
            41: p = 32'h0000002f; 42: p = 32'h00000030; 43: p = 32'h00000031;
            44: p = 32'h00000032; 45: p = 32'h00000033; 46: p = 32'h00000034;
            47: p = 32'h00000036;
            48: p = 32'h42000001; 49: p = 32'h42000002; 50: p = 32'h42000006;
            51: p = 32'h42000008; 52: p = 32'h42000018; 53: p = 32'h42000019;
            54: p = 32'h4200001f; 55: p = 32'h42000020;
            56: p = 32'h40000000; 57: p = 32'h40800000; 58: p = 32'h41600000;
            59: p = 32'h41800000; 60: p = 32'h41c00000;
            61: p = 32'h45000000; 62: p = 32'h45010000; 63: p = 32'h45020000;
            64: p = 32'h45030000;
            65: p = 32'h46000000; 66: p = 32'h46000001; 67: p = 32'h46000002;
            68: p = 32'h46000003; 69: p = 32'h46000004; 70: p = 32'h46000005;
            71: p = 32'h46000006; 72: p = 32'h46000007; 73: p = 32'h4600000c;
            74: p = 32'h4600000d; 75: p = 32'h4600000e; 76: p = 32'h4600000f;
            77: p = 32'h46000024; 78: p = 32'h46000026; 79: p = 32'h46000030;
            80: p = 32'h46000031; 81: p = 32'h46000032; 82: p = 32'h46000033;
            83: p = 32'h46000034; 84: p = 32'h46000036; 85: p = 32'h46000037;
            86: p = 32'h46000038; 87: p = 32'h46000039; 88: p = 32'h4600003a;
            89: p = 32'h4600003c; 90: p = 32'h4600003d; 91: p = 32'h4600003e;
            92: p = 32'h4600003f;
            93: p = 32'h46800020;
            94: p = 32'h44000000; 95: p = 32'h44400000; 96: p = 32'h44800000;
            97: p = 32'h44c00000;
            98: p = 32'h49000000; 99: p = 32'h49010000; 100: p = 32'h49020000;
            101: p = 32'h49030000;
            102: p = 32'h48000000; 103: p = 32'h48400000; 104: p = 32'h48600000;
            105: p = 32'h48800000; 106: p = 32'h48c00000; 107: p = 32'h48e00000;
            108: p = 32'h60000000; 109: p = 32'h60800000; 110: p = 32'h61000000;
            111: p = 32'h63800000;
            112: p = 32'h64000000; 113: p = 32'h64800000; 114: p = 32'h65000000;
            115: p = 32'h66000000; 116: p = 32'h66800000; 117: p = 32'h67000000;
            118: p = 32'h6c000000; 119: p = 32'h6d000000; 120: p = 32'h6d800000;
            121: p = 32'h6e800000; 122: p = 32'h6f000000; 123: p = 32'h6f800000;
            124: p = 32'h70000000; 125: p = 32'h70000024; 126: p = 32'h70000026;
            127: p = 32'h7c0000a0; 128: p = 32'h7c0000e0; 129: p = 32'h7c000420;
            130: p = 32'h7c000520; 131: p = 32'h7c000620;
            132: p = 32'h7c000000; 133: p = 32'h7c000004; 134: p = 32'h7c00003b;
            135: p = 32'h08000000; 136: p = 32'h0c000000; 137: p = 32'h10000000;
            138: p = 32'h14000000; 139: p = 32'h18000000; 140: p = 32'h1c000000;
            141: p = 32'h20000000; 142: p = 32'h24000000; 143: p = 32'h28000000;
            144: p = 32'h2c000000; 145: p = 32'h30000000; 146: p = 32'h34000000;
            147: p = 32'h38000000; 148: p = 32'h3c000000; 149: p = 32'h50000000;
            150: p = 32'h54000000; 151: p = 32'h58000000; 152: p = 32'h5c000000;
            153: p = 32'h5c000000; 154: p = 32'h80000000; 155: p = 32'h84000000;
            156: p = 32'h88000000; 157: p = 32'h8c000000; 158: p = 32'h90000000;
            159: p = 32'h94000000; 160: p = 32'h98000000; 161: p = 32'ha0000000;
            162: p = 32'ha4000000; 163: p = 32'ha8000000; 164: p = 32'hac000000;
            165: p = 32'hb8000000; 166: p = 32'hbc000000; 167: p = 32'hc0000000;
            168: p = 32'hc4000000; 169: p = 32'hc8000000;
            default: p = '0;
        endcase
        return p;
    endfunction

    // mask, lo, hi, first, count
    function automatic logic [111:0] group_at(input int g);
        logic [111:0] r;
        unique case (g)
            0:  r = {32'hffe0003f, 32'h00000002, 32'h00200002, 8'd1,   8'd2};
            1:  r = {32'hfc00007f, 32'h00000006, 32'h00000046, 8'd3,   8'd2};
            2:  r = {32'hfc00003f, 32'h00000000, 32'h0000003f, 8'd5,   8'd43};
            3:  r = {32'hfe00003f, 32'h42000000, 32'h4200003f, 8'd48,  8'd8};
            4:  r = {32'hffe00000, 32'h40000000, 32'h43e00000, 8'd56,  8'd5};
            5:  r = {32'hffff0000, 32'h45000000, 32'h451f0000, 8'd61,  8'd4};
            6:  r = {32'hffe0003f, 32'h46000000, 32'h4600003f, 8'd65,  8'd28};
            7:  r = {32'hffe0003f, 32'h46800000, 32'h4680003f, 8'd93,  8'd1};
            8:  r = {32'hffe00000, 32'h44000000, 32'h47e00000, 8'd94,  8'd4};
            9:  r = {32'hffe30000, 32'h49000000, 32'h49030000, 8'd98,  8'd4};
            10: r = {32'hffe00000, 32'h48000000, 32'h4be00000, 8'd102, 8'd6};
            11: r = {32'hff800000, 32'h60000000, 32'h63800000, 8'd108, 8'd4};
            12: r = {32'hff800000, 32'h64000000, 32'h67800000, 8'd112, 8'd6};
            13: r = {32'hff800000, 32'h6c000000, 32'h6f800000, 8'd118, 8'd6};
            14: r = {32'hfc00003f, 32'h70000000, 32'h7000003f, 8'd124, 8'd3};
            15: r = {32'hfc0007ff, 32'h7c000020, 32'h7c0007e0, 8'd127, 8'd5};
            16: r = {32'hfc00003f, 32'h7c000000, 32'h7c00003f, 8'd132, 8'd3};
            17: r = {32'hfc000000, 32'h00000000, 32'hfc000000, 8'd135, 8'd35};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/moc_match.sv =====
// Parallel mask/range/pattern compare over all groups; priority pick of first hit.
// Depends on moc_pkg.
module moc_match (
    input  moc_pkg::word_t  word,
    output moc_pkg::class_t result
);
    import moc_pkg::*;

    logic [NumPatterns-1:0] hit;

    always_comb begin
        logic [111:0] gd;
        word_t        m;
        logic         in_range;
        hit = '0;
        hit[0] = (word == '0);
        for (int g = 0; g < NumGroups; g++) begin
            gd = group_at(g);
            m = word & gd[111:80];
            in_range = (m >= gd[79:48]) && (m <= gd[47:16]);
            for (int k = 1; k < NumPatterns; k++) begin
                if (k >= int'(gd[15:8]) && k < int'(gd[15:8]) + int'(gd[7:0])) begin
                    hit[k] = in_range && (m == pattern_at(k));
                end
            end
        end
    end

    always_comb begin
        result = '0;
        for (int k = NumPatterns - 1; k >= 0; k--) begin
            if (hit[k]) begin
                result.known = 1'b1;
                result.id    = id_t'(k);
            end
        end
    end

endmodule

// ===== hw/rtl/mips_opcode_classifier.sv =====
// Path: each s_axis word is held in the input register, then in the result register, which
// drives m_axis; m_axis tvalid rises when the result register loads a valid word.
// Throughput: one word per cycle while m_axis is ready; all pattern compares run in parallel in one stage.
// Backpressure holds the result register; the input register still fills while it is empty.
// Reset (aresetn low, synchronous): clears valids, byte offset and base address.
// Depends on moc_pkg, moc_match.
module mips_opcode_classifier (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  moc_pkg::word_t      s_axis_tdata,   // [31:0] opcode_word
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [79:0]         m_axis_tdata    // [31:0] word_address, [63:32] echoed_word,
                                                // [64] is_known, [72:65] instr_id, [79:73] zero
);
    import moc_pkg::*;

    word_t  base_reg;
    word_t  offset_reg;
    item_t  in_reg;
    logic   in_valid_reg;
    item_t  out_reg;
    class_t cls_reg;
    logic   out_valid_reg;
    class_t cls;
    logic   adv_out;
    logic   adv_in;

    moc_match u_match (.word(in_reg.word), .result(cls));

    assign adv_out       = !out_valid_reg || m_axis_tready;
    assign adv_in        = !in_valid_reg || adv_out;
    assign s_axis_tready = adv_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            offset_reg    <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (adv_in) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv_in && s_axis_tvalid) begin
                in_reg.addr <= base_reg + offset_reg;
                in_reg.word <= s_axis_tdata;
                offset_reg  <= offset_reg + 32'd4;
            end
            if (adv_out) begin
                out_valid_reg <= in_valid_reg;
                out_reg       <= in_reg;
                cls_reg       <= cls;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, cls_reg.id, cls_reg.known, out_reg.word, out_reg.addr};

endmodule

// ===== hw/rtl/moc_checker.sv =====
// Port-level checker for mips_opcode_classifier, bound to the top level.
// Depends on mips_opcode_classifier ports only.
module moc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_unknown_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[64] |-> m_axis_tdata[72:65] == 8'd0)
        else $error("unknown word with nonzero id");

    a_nop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[63:32] == 32'd0 |->
            m_axis_tdata[64] && m_axis_tdata[72:65] == 8'd0)
        else $error("zero word not nop");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[79:73] == 7'd0 && m_axis_tdata[72:65] <= 8'd169)
        else $error("id out of range");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output free");
endmodule

bind mips_opcode_classifier moc_checker u_moc_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== bench/tb.sv =====
// Testbench for mips_opcode_classifier: directed and random opcode words checked
// against an in-bench classifier and address counter. Depends on moc_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
    import moc_pkg::*;

    localparam int NUM_GROUPS_TB = 18;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    word_t       s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    typedef struct {
        logic [31:0] addr;
        logic [31:0] word;
        logic        known;
        logic [7:0]  id;
    } decode_t;

    decode_t     decode_q[$];
    logic [31:0] base_addr_mdl;
    logic [31:0] offset_mdl;
    int          errors = 0;
    int          sent = 0;
    int          checked = 0;
    int          unknown_seen = 0;
    int          burst_left = 0;
    bit          rx_always = 1'b0;

    mips_opcode_classifier u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Opcode table, in id order.
    logic [31:0] op_tbl [0:169] = '{
        32'h00000000,
        32'h00000002, 32'h00200002, 32'h00000006, 32'h00000046,
        32'h00000000, 32'h00000003, 32'h00000004, 32'h00000007, 32'h00000008, 32'h00000009,
        32'h0000000a, 32'h0000000b, 32'h0000000c, 32'h0000000d, 32'h0000000f,
        32'h00000010, 32'h00000011, 32'h00000012, 32'h00000013, 32'h00000016, 32'h00000017,
        32'h00000018, 32'h00000019, 32'h0000001a, 32'h0000001b, 32'h0000001c, 32'h0000001d,
        32'h00000020, 32'h00000021, 32'h00000022, 32'h00000023, 32'h00000024, 32'h00000025,
        32'h00000026, 32'h00000027, 32'h0000002a, 32'h0000002b, 32'h0000002c, 32'h0000002d,
        32'h0000002e, 32'h0000002f, 32'h00000030, 32'h00000031, 32'h00000032, 32'h00000033,
        32'h00000034, 32'h00000036,
        32'h42000001, 32'h42000002, 32'h42000006, 32'h42000008, 32'h42000018, 32'h42000019,
        32'h4200001f, 32'h42000020,
        32'h40000000, 32'h40800000, 32'h41600000, 32'h41800000, 32'h41c00000,
        32'h45000000, 32'h45010000, 32'h45020000, 32'h45030000,
        32'h46000000, 32'h46000001, 32'h46000002, 32'h46000003, 32'h46000004, 32'h46000005,
        32'h46000006, 32'h46000007, 32'h4600000c, 32'h4600000d, 32'h4600000e, 32'h4600000f,
        32'h46000024, 32'h46000026, 32'h46000030, 32'h46000031, 32'h46000032, 32'h46000033,
        32'h46000034, 32'h46000036, 32'h46000037, 32'h46000038, 32'h46000039, 32'h4600003a,
        32'h4600003c, 32'h4600003d, 32'h4600003e, 32'h4600003f,
        32'h46800020,
        32'h44000000, 32'h44400000, 32'h44800000, 32'h44c00000,
        32'h49000000, 32'h49010000, 32'h49020000, 32'h49030000,
        32'h48000000, 32'h48400000, 32'h48600000, 32'h48800000, 32'h48c00000, 32'h48e00000,
        32'h60000000, 32'h60800000, 32'h61000000, 32'h63800000,
        32'h64000000, 32'h64800000, 32'h65000000, 32'h66000000, 32'h66800000, 32'h67000000,
        32'h6c000000, 32'h6d000000, 32'h6d800000, 32'h6e800000, 32'h6f000000, 32'h6f800000,
        32'h70000000, 32'h70000024, 32'h70000026,
        32'h7c0000a0, 32'h7c0000e0, 32'h7c000420, 32'h7c000520, 32'h7c000620,
        32'h7c000000, 32'h7c000004, 32'h7c00003b,
        32'h08000000, 32'h0c000000, 32'h10000000, 32'h14000000, 32'h18000000, 32'h1c000000,
        32'h20000000, 32'h24000000, 32'h28000000, 32'h2c000000, 32'h30000000, 32'h34000000,
        32'h38000000, 32'h3c000000, 32'h50000000, 32'h54000000, 32'h58000000, 32'h5c000000,
        32'h5c000000, 32'h80000000, 32'h84000000, 32'h88000000, 32'h8c000000, 32'h90000000,
        32'h94000000, 32'h98000000, 32'ha0000000, 32'ha4000000, 32'ha8000000, 32'hac000000,
        32'hb8000000, 32'hbc000000, 32'hc0000000, 32'hc4000000, 32'hc8000000
    };

    logic [31:0] grp_mask [0:17] = '{
        32'hffe0003f, 32'hfc00007f, 32'hfc00003f, 32'hfe00003f, 32'hffe00000, 32'hffff0000,
        32'hffe0003f, 32'hffe0003f, 32'hffe00000, 32'hffe30000, 32'hffe00000, 32'hff800000,
        32'hff800000, 32'hff800000, 32'hfc00003f, 32'hfc0007ff, 32'hfc00003f, 32'hfc000000
    };
    logic [31:0] grp_lo [0:17] = '{
        32'h00000002, 32'h00000006, 32'h00000000, 32'h42000000, 32'h40000000, 32'h45000000,
        32'h46000000, 32'h46800000, 32'h44000000, 32'h49000000, 32'h48000000, 32'h60000000,
        32'h64000000, 32'h6c000000, 32'h70000000, 32'h7c000020, 32'h7c000000, 32'h00000000
    };
    logic [31:0] grp_hi [0:17] = '{
        32'h00200002, 32'h00000046, 32'h0000003f, 32'h4200003f, 32'h43e00000, 32'h451f0000,
        32'h4600003f, 32'h4680003f, 32'h47e00000, 32'h49030000, 32'h4be00000, 32'h63800000,
        32'h67800000, 32'h6f800000, 32'h7000003f, 32'h7c0007e0, 32'h7c00003f, 32'hfc000000
    };
    int grp_first [0:17] = '{1, 3, 5, 48, 56, 61, 65, 93, 94, 98, 102, 108, 112, 118,
                             124, 127, 132, 135};
    int grp_count [0:17] = '{2, 2, 43, 8, 5, 4, 28, 1, 4, 4, 6, 4, 6, 6, 3, 5, 3, 35};

    function automatic void decode_word(input logic [31:0] w, output logic known,
                                        output logic [7:0] id);
        logic [31:0] m;
        known = 1'b1;
        id = '0;
        if (w == '0) return;
        for (int g = 0; g < NUM_GROUPS_TB; g++) begin
            m = w & grp_mask[g];
            if (m >= grp_lo[g] && m <= grp_hi[g]) begin
                for (int k = 0; k < grp_count[g]; k++) begin
                    if (op_tbl[grp_first[g] + k] == m) begin
                        id = 8'(grp_first[g] + k);
                        return;
                    end
                end
            end
        end
        known = 1'b0;
    endfunction

    // Predict at the accepting edge.
    always @(posedge aclk) begin
        decode_t d;
        if (!aresetn) begin
            offset_mdl <= '0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            d.addr = base_addr_mdl + offset_mdl;
            d.word = s_axis_tdata;
            decode_word(s_axis_tdata, d.known, d.id);
            if (!d.known) unknown_seen++;
            decode_q.push_back(d);
            offset_mdl <= offset_mdl + 32'd4;
        end
    end

    always @(posedge aclk) begin
        decode_t d;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (decode_q.size() == 0) begin
                $display("%0t: unexpected transfer %h", $time, m_axis_tdata);
                errors++;
            end else begin
                d = decode_q.pop_front();
                checked++;
                if (m_axis_tdata[31:0] !== d.addr) begin
                    $display("%0t: addr exp %h got %h", $time, d.addr, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== d.word) begin
                    $display("%0t: word exp %h got %h", $time, d.word, m_axis_tdata[63:32]);
                    errors++;
                end
                if (m_axis_tdata[64] !== d.known) begin
                    $display("%0t: known exp %b got %b (word %h)", $time, d.known,
                             m_axis_tdata[64], d.word);
                    errors++;
                end
                if (m_axis_tdata[72:65] !== d.id) begin
                    $display("%0t: id exp %0d got %0d (word %h)", $time, d.id,
                             m_axis_tdata[72:65], d.word);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern.
    always @(negedge aclk) begin
        if (rx_always) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 9) < 7);
    end

    task automatic send_word(input logic [31:0] w);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (decode_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_base(input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        base_addr_mdl = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed();
        logic [31:0] dir [] = '{32'h00000000, 32'hffffffff, 32'h00000002, 32'h00200002,
            32'h00000046, 32'h0000003f, 32'h42000020, 32'h41c00000, 32'h451f0000,
            32'h46800020, 32'h49030000, 32'h4be00000, 32'h63800000, 32'h6f800000,
            32'h70000026, 32'h7c000620, 32'h7c00003b, 32'h5c000000, 32'hc8000000,
            32'hfc000000, 32'h5fffffff, 32'haaaaaaaa, 32'h55555555};
        set_base(32'h0);
        foreach (dir[i]) send_word(dir[i]);
        drain();
    endtask

    task automatic test_table_walk();
        set_base(32'hfffffff0);
        for (int i = 0; i < 170; i++) send_word(op_tbl[i] | ($urandom & ~(32'hfc000000)
                                                           & ~(i == 0 ? 32'h0 : 32'hffffffff)));
        drain();
    endtask

    task automatic test_random(input int n);
        logic [31:0] w;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: w = $urandom;
                1: w = op_tbl[$urandom_range(0, 169)];
                default: begin
                    w = op_tbl[$urandom_range(1, 169)];
                    w = w | ($urandom & ~grp_mask[$urandom_range(0, 17)]);
                end
            endcase
            send_word(w);
        end
        drain();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_table_walk();
        set_base(32'hffffffff);
        test_random(300);
        rx_always = 1'b1;
        set_base($urandom);
        test_random(200);
        rx_always = 1'b0;
        set_base(32'h80000000);
        test_random(100);
        $display("Sent %0d words, checked %0d results, %0d unknown; base addresses incl. 0",
                 sent, checked, unknown_seen);
        $display("and all-ones, word addresses wrapping through 2^32.");
        if (errors == 0 && decode_q.size() == 0)
            $display("mips_opcode_classifier regression: pass");
        else
            $display("mips_opcode_classifier regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("mips_opcode_classifier regression: fail");
        $finish;
    end
endmodule
